@@ rtl/ppni_pkg.sv @@
// Shared widths, register indexes and payload types for the plane inlier test.
package ppni_pkg;

	localparam int COORD_W  = 32;
	localparam int NORMAL_W = 16;
	localparam int THR_W    = 32;
	localparam int TRIG_W   = 16;
	localparam int CFG_W    = 32;
	localparam int IDX_W    = 3;
	localparam int MUL_LAT  = 4;

	typedef logic [IDX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_PLANE_A      = 3'd0;
	localparam cfg_index_t REG_PLANE_B      = 3'd1;
	localparam cfg_index_t REG_PLANE_C      = 3'd2;
	localparam cfg_index_t REG_PLANE_OFFSET = 3'd3;
	localparam cfg_index_t REG_DIST_THR     = 3'd4;
	localparam cfg_index_t REG_ANGLE_COS    = 3'd5;
	localparam cfg_index_t REG_ANGLE_SIN    = 3'd6;

	typedef struct packed {
		logic signed [COORD_W-1:0]  point_x;
		logic signed [COORD_W-1:0]  point_y;
		logic signed [COORD_W-1:0]  point_z;
		logic signed [NORMAL_W-1:0] normal_x;
		logic signed [NORMAL_W-1:0] normal_y;
		logic signed [NORMAL_W-1:0] normal_z;
	} point_t;

	typedef struct packed {
		logic inlier;
		logic distance_ok;
		logic angle_ok;
	} result_t;

endpackage

@@ rtl/ppni_mul.sv @@
// Pipelined exact signed multiplier built from 32x32 partial products.
module ppni_mul #(
	parameter int WA = 32,
	parameter int WB = 32
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic signed [WA+WB-1:0] p
);
	localparam int NA = (WA + 31) / 32;
	localparam int NB = (WB + 31) / 32;
	localparam int PW = NA * 32 + NB * 32;

	logic [WA-1:0]      abs_a;
	logic [WB-1:0]      abs_b;
	logic [NA*32-1:0]   ma_s1;
	logic [NB*32-1:0]   mb_s1;
	logic               neg_s1, neg_s2, neg_s3;
	logic [63:0]        pp_s2 [NA*NB];
	logic [PW-1:0]      acc;
	logic [PW-1:0]      sum_s3;
	logic signed [WA+WB-1:0] p_s4;

	assign abs_a = a[WA-1] ? WA'(-a) : WA'(a);
	assign abs_b = b[WB-1] ? WB'(-b) : WB'(b);

	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (PW'(pp_s2[i*NB+j]) << (32 * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= (NA*32)'(abs_a);
			mb_s1  <= (NB*32)'(abs_b);
			neg_s1 <= a[WA-1] ^ b[WB-1];
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i*NB+j] <= 64'(ma_s1[i*32 +: 32]) * 64'(mb_s1[j*32 +: 32]);
				end
			end
			neg_s2 <= neg_s1;
			sum_s3 <= acc;
			neg_s3 <= neg_s2;
			p_s4   <= neg_s3 ? -$signed(sum_s3[WA+WB-1:0]) : $signed(sum_s3[WA+WB-1:0]);
		end
	end

	assign p = p_s4;

endmodule

@@ rtl/ppni_dly.sv @@
// Enabled delay line that keeps data aligned with the multiplier stages.
module ppni_dly #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);
	logic [W-1:0] tap_q [D];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int k = 1; k < D; k++) begin
				tap_q[k] <= tap_q[k-1];
			end
		end
	end

	assign dout = tap_q[D-1];

endmodule

@@ rtl/plane_point_normal_inlier_test_core.sv @@
// Plane inlier test: point distance and normal angle against a configured plane.
//
// Channels: points enter on in_valid/in_ready with in_item, results leave on
// out_valid/out_ready with out_item, and registers are written on
// cfg_valid/cfg_ready with cfg_index and cfg_data. cfg_ready is always high;
// write registers only while no point is in flight.
// One point enters per cycle while the output is not stalled: three 4-stage
// multiplier groups (linear terms, squares, angle products) with an add stage
// after the first two and a compare stage at the output.
// A point is taken in every cycle in which the output register is empty or
// being drained, so sustained throughput is one point per cycle.
// When the receiver stalls the whole pipeline holds, in_ready drops and the
// waiting result stays unchanged on out_item; nothing is lost or repeated.
// Reset clears all valid bits and loads the register reset values: zero plane,
// zero threshold, cosine 1.0 and sine 0.
// A zero plane normal fails both tests; a zero point normal passes the angle
// test exactly when the sine register is nonzero.
module plane_point_normal_inlier_test_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ppni_pkg::point_t    in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output ppni_pkg::result_t   out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  ppni_pkg::cfg_index_t cfg_index,
	input  logic [ppni_pkg::CFG_W-1:0] cfg_data
);
	import ppni_pkg::*;

	localparam int CW   = COORD_W;
	localparam int NW   = NORMAL_W;
	localparam int SW   = 2 * CW + 2;
	localparam int XW   = NW + CW + 1;
	localparam int DW   = NW + CW + 2;
	localparam int TW   = TRIG_W + 1;
	localparam int RW   = SW + THR_W + 1 + 16;
	localparam int CR2W = 2 * XW + 2;
	localparam int LAT  = 3 * MUL_LAT + 3;

	logic signed [CW-1:0] plane_a_q, plane_b_q, plane_c_q, plane_offset_q;
	logic [THR_W-1:0]     dist_thr_q;
	logic [TRIG_W-1:0]    angle_cos_q, angle_sin_q;

	logic [LAT-1:0] v_q;
	logic           en;

	assign cfg_ready = 1'b1;
	assign en        = !v_q[LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = v_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_a_q      <= '0;
			plane_b_q      <= '0;
			plane_c_q      <= '0;
			plane_offset_q <= '0;
			dist_thr_q     <= '0;
			angle_cos_q    <= TRIG_W'(32768);
			angle_sin_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PLANE_A:      plane_a_q      <= CW'(cfg_data);
				REG_PLANE_B:      plane_b_q      <= CW'(cfg_data);
				REG_PLANE_C:      plane_c_q      <= CW'(cfg_data);
				REG_PLANE_OFFSET: plane_offset_q <= CW'(cfg_data);
				REG_DIST_THR:     dist_thr_q     <= THR_W'(cfg_data);
				REG_ANGLE_COS:    angle_cos_q    <= TRIG_W'(cfg_data);
				REG_ANGLE_SIN:    angle_sin_q    <= TRIG_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LAT-2:0], in_valid};
		end
	end

	// First group: linear terms, plane norm terms and cross/dot terms.
	logic signed [2*CW-1:0] ax, by, cz, aa, bb, cc;
	logic signed [NW+CW-1:0] nyc, nzb, nza, nxc, nxb, nya, nxa, nyb, nzc;

	ppni_mul #(.WA(CW), .WB(CW)) u_ax (.clk, .en, .a(plane_a_q), .b(in_item.point_x), .p(ax));
	ppni_mul #(.WA(CW), .WB(CW)) u_by (.clk, .en, .a(plane_b_q), .b(in_item.point_y), .p(by));
	ppni_mul #(.WA(CW), .WB(CW)) u_cz (.clk, .en, .a(plane_c_q), .b(in_item.point_z), .p(cz));
	ppni_mul #(.WA(CW), .WB(CW)) u_aa (.clk, .en, .a(plane_a_q), .b(plane_a_q), .p(aa));
	ppni_mul #(.WA(CW), .WB(CW)) u_bb (.clk, .en, .a(plane_b_q), .b(plane_b_q), .p(bb));
	ppni_mul #(.WA(CW), .WB(CW)) u_cc (.clk, .en, .a(plane_c_q), .b(plane_c_q), .p(cc));
	ppni_mul #(.WA(NW), .WB(CW)) u_nyc (.clk, .en, .a(in_item.normal_y), .b(plane_c_q), .p(nyc));
	ppni_mul #(.WA(NW), .WB(CW)) u_nzb (.clk, .en, .a(in_item.normal_z), .b(plane_b_q), .p(nzb));
	ppni_mul #(.WA(NW), .WB(CW)) u_nza (.clk, .en, .a(in_item.normal_z), .b(plane_a_q), .p(nza));
	ppni_mul #(.WA(NW), .WB(CW)) u_nxc (.clk, .en, .a(in_item.normal_x), .b(plane_c_q), .p(nxc));
	ppni_mul #(.WA(NW), .WB(CW)) u_nxb (.clk, .en, .a(in_item.normal_x), .b(plane_b_q), .p(nxb));
	ppni_mul #(.WA(NW), .WB(CW)) u_nya (.clk, .en, .a(in_item.normal_y), .b(plane_a_q), .p(nya));
	ppni_mul #(.WA(NW), .WB(CW)) u_nxa (.clk, .en, .a(in_item.normal_x), .b(plane_a_q), .p(nxa));
	ppni_mul #(.WA(NW), .WB(CW)) u_nyb (.clk, .en, .a(in_item.normal_y), .b(plane_b_q), .p(nyb));
	ppni_mul #(.WA(NW), .WB(CW)) u_nzc (.clk, .en, .a(in_item.normal_z), .b(plane_c_q), .p(nzc));

	logic signed [SW-1:0] s_s5, nn_s5;
	logic signed [XW-1:0] cx_s5, cy_s5, cz_s5;
	logic signed [DW-1:0] dot_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s5   <= SW'(ax) + SW'(by) + SW'(cz) + (SW'(plane_offset_q) <<< 16);
			nn_s5  <= SW'(aa) + SW'(bb) + SW'(cc);
			cx_s5  <= XW'(nyc) - XW'(nzb);
			cy_s5  <= XW'(nza) - XW'(nxc);
			cz_s5  <= XW'(nxb) - XW'(nya);
			dot_s5 <= DW'(nxa) + DW'(nyb) + DW'(nzc);
		end
	end

	// Second group: squares and the threshold scaling.
	logic signed [2*SW-1:0]        ss;
	logic signed [SW+THR_W:0]      nt;
	logic signed [2*XW-1:0]        cx2, cy2, cz2;
	logic signed [2*DW-1:0]        d2;
	logic signed [2*TW-1:0]        cs, sn;

	ppni_mul #(.WA(SW), .WB(SW)) u_ss (.clk, .en, .a(s_s5), .b(s_s5), .p(ss));
	ppni_mul #(.WA(SW), .WB(THR_W+1)) u_nt (
		.clk, .en, .a(nn_s5), .b($signed({1'b0, dist_thr_q})), .p(nt));
	ppni_mul #(.WA(XW), .WB(XW)) u_cx2 (.clk, .en, .a(cx_s5), .b(cx_s5), .p(cx2));
	ppni_mul #(.WA(XW), .WB(XW)) u_cy2 (.clk, .en, .a(cy_s5), .b(cy_s5), .p(cy2));
	ppni_mul #(.WA(XW), .WB(XW)) u_cz2 (.clk, .en, .a(cz_s5), .b(cz_s5), .p(cz2));
	ppni_mul #(.WA(DW), .WB(DW)) u_d2 (.clk, .en, .a(dot_s5), .b(dot_s5), .p(d2));
	ppni_mul #(.WA(TW), .WB(TW)) u_cs (
		.clk, .en, .a($signed({1'b0, angle_cos_q})), .b($signed({1'b0, angle_cos_q})), .p(cs));
	ppni_mul #(.WA(TW), .WB(TW)) u_sn (
		.clk, .en, .a($signed({1'b0, angle_sin_q})), .b($signed({1'b0, angle_sin_q})), .p(sn));

	logic signed [2*SW-1:0] lhs_s10;
	logic signed [RW-1:0]   rhs_s10;
	logic signed [CR2W-1:0] cr2_s10;
	logic signed [2*DW-1:0] d2_s10;
	logic signed [2*TW-1:0] cs_s10, sn_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			lhs_s10 <= ss;
			rhs_s10 <= RW'(nt) <<< 16;
			cr2_s10 <= CR2W'(cx2) + CR2W'(cy2) + CR2W'(cz2);
			d2_s10  <= d2;
			cs_s10  <= cs;
			sn_s10  <= sn;
		end
	end

	// Third group: the two sides of the angle test.
	logic signed [CR2W+2*TW-1:0] ang_l;
	logic signed [4*DW+2*TW-2*DW-1:0] ang_r;

	ppni_mul #(.WA(CR2W), .WB(2*TW)) u_al (.clk, .en, .a(cr2_s10), .b(cs_s10), .p(ang_l));
	ppni_mul #(.WA(2*DW), .WB(2*TW)) u_ar (.clk, .en, .a(d2_s10), .b(sn_s10), .p(ang_r));

	logic [2*SW-1:0] lhs_d;
	logic [RW-1:0]   rhs_d;
	logic            nzero_d;
	logic            nzero_in;

	assign nzero_in = (in_item.normal_x == '0) && (in_item.normal_y == '0)
		&& (in_item.normal_z == '0);

	ppni_dly #(.W(2*SW), .D(MUL_LAT)) u_lhs_dly (.clk, .en, .din(lhs_s10), .dout(lhs_d));
	ppni_dly #(.W(RW), .D(MUL_LAT)) u_rhs_dly (.clk, .en, .din(rhs_s10), .dout(rhs_d));
	ppni_dly #(.W(1), .D(LAT-1)) u_nz_dly (.clk, .en, .din(nzero_in), .dout(nzero_d));

	logic plane_zero, dist_ok, ang_ok;

	assign plane_zero = (plane_a_q == '0) && (plane_b_q == '0) && (plane_c_q == '0);
	assign dist_ok    = !plane_zero && ($signed(lhs_d) < $signed(rhs_d));

	always_comb begin
		if (plane_zero) begin
			ang_ok = 1'b0;
		end else if (nzero_d) begin
			ang_ok = (angle_sin_q != '0);
		end else begin
			ang_ok = (ang_l < ang_r);
		end
	end

	result_t res_s15;

	always_ff @(posedge clk) begin
		if (en) begin
			res_s15.inlier      <= dist_ok && ang_ok;
			res_s15.distance_ok <= dist_ok;
			res_s15.angle_ok    <= ang_ok;
		end
	end

	assign out_item = res_s15;

endmodule

@@ rtl/ppni_checker.sv @@
// Port-level checks for the plane inlier test, bound to the top level.
module ppni_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input ppni_pkg::result_t out_item,
	input logic              out_valid,
	input logic              out_ready
);
	import ppni_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result beat changed while stalled");

	a_and: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.inlier == (out_item.distance_ok && out_item.angle_ok))
		else $error("inlier is not the AND of both tests");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow the output stall");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input beat taken while output stalled");

endmodule

bind plane_point_normal_inlier_test_core ppni_checker u_ppni_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_item(out_item),
	.out_valid(out_valid),
	.out_ready(out_ready)
);
